>>> src/rfg_pkg.sv
`default_nettype none

package rfg_pkg;

    localparam int COORD_W = 7;
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    // Commands from the sequencer to the rectangle walker
    typedef struct packed {
        logic init;
        logic step;
    } walk_cmd_t;

endpackage

`default_nettype wire

>>> src/rfg_ram.sv
`default_nettype none

module rfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                            wdata,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> src/rfg_walk.sv
`default_nettype none

module rfg_walk #(
    parameter int GRID_COLS = 128,
    parameter int AW        = 14
) (
    input  wire logic                         clk,
    input  wire rfg_pkg::walk_cmd_t           cmd,
    input  wire logic [rfg_pkg::COORD_W-1:0]  row_first,
    input  wire logic [rfg_pkg::COORD_W-1:0]  col_first,
    input  wire logic [rfg_pkg::COORD_W-1:0]  row_last,
    input  wire logic [rfg_pkg::COORD_W-1:0]  col_last,
    input  wire logic [AW-1:0]                base_addr,
    output logic      [AW-1:0]                addr,
    output logic                              last
);

    logic [rfg_pkg::COORD_W-1:0] row_reg, row_next;
    logic [rfg_pkg::COORD_W-1:0] col_reg, col_next;
    logic [rfg_pkg::COORD_W-1:0] col_first_reg;
    logic [rfg_pkg::COORD_W-1:0] col_last_reg;
    logic [rfg_pkg::COORD_W-1:0] row_last_reg;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [AW-1:0]               stride_reg;
    logic                        col_end;
    logic                        row_end;

    assign col_end = (col_reg == col_last_reg);
    assign row_end = (row_reg == row_last_reg);
    assign last    = col_end && row_end;
    assign addr    = addr_reg;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        addr_next = addr_reg;
        if (cmd.init)
        begin
            row_next  = row_first;
            col_next  = col_first;
            addr_next = base_addr;
        end
        else if (cmd.step)
        begin
            // One adder moves along the row or jumps to the next row's start
            addr_next = addr_reg + (col_end ? stride_reg : AW'(1));
            if (col_end)
            begin
                col_next = col_first_reg;
                row_next = row_reg + rfg_pkg::COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + rfg_pkg::COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        addr_reg <= addr_next;
        if (cmd.init)
        begin
            col_first_reg <= col_first;
            col_last_reg  <= col_last;
            row_last_reg  <= row_last;
            stride_reg    <= AW'(GRID_COLS) - (AW'(col_last) - AW'(col_first));
        end
    end

endmodule

`default_nettype wire

>>> src/rectangle_fill_grid_store_top.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// item      in         start, accepted if !busy  mode, row_first, col_first,
//                                                row_last, col_last, cell_value
// result    out        done, one-cycle strobe    read_value, status
//
// A load and a bad or empty fill finish in the execute state, a valid read
// also passes the data state for the registered RAM read, and a fill walks
// the rectangle, one cell per cycle through the single RAM write port.
// busy is high from the cycle after acceptance until done is raised; a new
// item may be accepted in the cycle done is shown.
// Reset is asynchronous, active low; grid contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.

module rectangle_fill_grid_store_top #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 128
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic        [rfg_pkg::MODE_W-1:0]  mode,
    input  wire logic        [rfg_pkg::COORD_W-1:0] row_first,
    input  wire logic        [rfg_pkg::COORD_W-1:0] col_first,
    input  wire logic        [rfg_pkg::COORD_W-1:0] row_last,
    input  wire logic        [rfg_pkg::COORD_W-1:0] col_last,
    input  wire logic signed [rfg_pkg::VALUE_W-1:0] cell_value,
    output logic                                    done,
    output logic signed      [rfg_pkg::VALUE_W-1:0] read_value,
    output logic                                    status
);

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_RDATA = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;
    logic       status_reg, status_next;
    logic [rfg_pkg::VALUE_W-1:0] read_value_reg, read_value_next;

    logic [rfg_pkg::MODE_W-1:0]  mode_reg;
    logic [rfg_pkg::COORD_W-1:0] row_first_reg;
    logic [rfg_pkg::COORD_W-1:0] col_first_reg;
    logic [rfg_pkg::COORD_W-1:0] row_last_reg;
    logic [rfg_pkg::COORD_W-1:0] col_last_reg;
    logic [rfg_pkg::VALUE_W-1:0] value_reg;

    logic                        accept;
    logic                        first_ok;
    logic                        last_ok;
    logic                        fill_empty;
    logic [AW-1:0]               base_addr;
    logic [AW-1:0]               walk_addr;
    logic                        walk_last;
    rfg_pkg::walk_cmd_t          walk_cmd;

    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [rfg_pkg::VALUE_W-1:0] ram_rdata;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    assign first_ok   = (int'(row_first_reg) < GRID_ROWS) && (int'(col_first_reg) < GRID_COLS);
    assign last_ok    = (int'(row_last_reg) < GRID_ROWS) && (int'(col_last_reg) < GRID_COLS);
    assign fill_empty = (row_first_reg > row_last_reg) || (col_first_reg > col_last_reg);
    assign base_addr  = AW'(int'(row_first_reg) * GRID_COLS + int'(col_first_reg));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            row_first_reg <= row_first;
            col_first_reg <= col_first;
            row_last_reg  <= row_last;
            col_last_reg  <= col_last;
            value_reg     <= cell_value;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        walk_cmd        = '0;
        ram_we          = 1'b0;
        ram_addr        = base_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                read_value_next = '0;
                status_next     = 1'b0;
                state_next      = S_IDLE;
                done_next       = 1'b1;
                unique case (mode_reg)
                    rfg_pkg::MODE_LOAD:
                    begin
                        ram_we      = first_ok;
                        status_next = !first_ok;
                    end
                    rfg_pkg::MODE_FILL:
                    begin
                        status_next = !(first_ok && last_ok);
                        if (first_ok && last_ok && !fill_empty)
                        begin
                            walk_cmd.init = 1'b1;
                            state_next    = S_FILL;
                            done_next     = 1'b0;
                        end
                    end
                    rfg_pkg::MODE_READ:
                    begin
                        status_next = !first_ok;
                        if (first_ok)
                        begin
                            state_next = S_RDATA;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        status_next = 1'b0;
                    end
                endcase
            end
            S_FILL:
            begin
                ram_we        = 1'b1;
                ram_addr      = walk_addr;
                walk_cmd.step = 1'b1;
                if (walk_last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_RDATA:
            begin
                read_value_next = ram_rdata;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            status_reg     <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = $signed(read_value_reg);

    rfg_walk #(
        .GRID_COLS (GRID_COLS),
        .AW        (AW)
    ) u_walk (
        .clk       (clk),
        .cmd       (walk_cmd),
        .row_first (row_first_reg),
        .col_first (col_first_reg),
        .row_last  (row_last_reg),
        .col_last  (col_last_reg),
        .base_addr (base_addr),
        .addr      (walk_addr),
        .last      (walk_last)
    );

    rfg_ram #(
        .WIDTH (rfg_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

`ifndef SYNTH
    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe without return to idle");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE))
        else $error("result strobe with no item in progress");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done_reg))
        else $error("accepted item did not raise busy");

    a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC || state_reg == S_FILL))
        else $error("grid write outside load or fill");

    a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> (read_value_reg == '0))
        else $error("bad coordinate result carries data");
`endif

endmodule

`default_nettype wire

>>> verif/tb_rectangle_fill_grid_store_top.sv
`default_nettype none

module tb_rectangle_fill_grid_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = rfg_pkg::COORD_W;
    localparam int VALUE_W = rfg_pkg::VALUE_W;
    localparam int MODE_W  = rfg_pkg::MODE_W;

    localparam logic [MODE_W-1:0] MODE_LOAD = rfg_pkg::MODE_LOAD;
    localparam logic [MODE_W-1:0] MODE_FILL = rfg_pkg::MODE_FILL;
    localparam logic [MODE_W-1:0] MODE_READ = rfg_pkg::MODE_READ;

    localparam int GRID_ROWS = 128;
    localparam int GRID_COLS = 128;

    localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(GRID_ROWS - 1);
    localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(GRID_COLS - 1);

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic STATUS_DONE      = 1'b0;
    localparam logic STATUS_BAD_COORD = 1'b1;

    localparam int RANDOM_ITEMS = 1030;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      stat;
    } cell_reply_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [MODE_W-1:0]           mode = MODE_LOAD;
    logic [COORD_W-1:0]          row_first = '0;
    logic [COORD_W-1:0]          col_first = '0;
    logic [COORD_W-1:0]          row_last = '0;
    logic [COORD_W-1:0]          col_last = '0;
    logic signed [VALUE_W-1:0]   cell_value = '0;
    logic                        busy;
    logic                        done;
    logic signed [VALUE_W-1:0]   read_value;
    logic                        status;

    logic signed [VALUE_W-1:0]   grid_image [0:GRID_ROWS*GRID_COLS-1];
    cell_reply_t                 pending_replies [$];
    int                          mismatch_count = 0;
    int                          burst_left = 0;

    // last written region, used to aim reads at live data
    logic [COORD_W-1:0]          area_r0 = '0;
    logic [COORD_W-1:0]          area_c0 = '0;
    logic [COORD_W-1:0]          area_r1 = '0;
    logic [COORD_W-1:0]          area_c1 = '0;

    rectangle_fill_grid_store_top #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .row_first  (row_first),
        .col_first  (col_first),
        .row_last   (row_last),
        .col_last   (col_last),
        .cell_value (cell_value),
        .done       (done),
        .read_value (read_value),
        .status     (status)
    );

    always #4 clk = ~clk;

    function automatic logic on_grid(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
        return (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
    endfunction

    function automatic cell_reply_t apply_grid_item(
        input logic [MODE_W-1:0]         m,
        input logic [COORD_W-1:0]        r0,
        input logic [COORD_W-1:0]        c0,
        input logic [COORD_W-1:0]        r1,
        input logic [COORD_W-1:0]        c1,
        input logic signed [VALUE_W-1:0] v
    );
        cell_reply_t reply;
        reply.value = '0;
        reply.stat  = STATUS_DONE;
        case (m)
            MODE_LOAD:
            begin
                if (on_grid(r0, c0))
                    grid_image[int'(r0) * GRID_COLS + int'(c0)] = v;
                else
                    reply.stat = STATUS_BAD_COORD;
            end
            MODE_FILL:
            begin
                // an inverted rectangle simply runs no iterations
                if (on_grid(r0, c0) && on_grid(r1, c1))
                begin
                    for (int r = int'(r0); r <= int'(r1); r++)
                        for (int c = int'(c0); c <= int'(c1); c++)
                            grid_image[r * GRID_COLS + c] = v;
                end
                else
                    reply.stat = STATUS_BAD_COORD;
            end
            MODE_READ:
            begin
                if (on_grid(r0, c0))
                    reply.value = grid_image[int'(r0) * GRID_COLS + int'(c0)];
                else
                    reply.stat = STATUS_BAD_COORD;
            end
            default: ;
        endcase
        return reply;
    endfunction

    // Sender pacing: bursts of back-to-back items separated by random idle gaps, which may be empty
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        burst_left--;
    endtask

    task automatic send_item(
        input logic [MODE_W-1:0]         m,
        input logic [COORD_W-1:0]        r0,
        input logic [COORD_W-1:0]        c0,
        input logic [COORD_W-1:0]        r1,
        input logic [COORD_W-1:0]        c1,
        input logic signed [VALUE_W-1:0] v
    );
        pace();
        start      <= 1'b1;
        mode       <= m;
        row_first  <= r0;
        col_first  <= c0;
        row_last   <= r1;
        col_last   <= c1;
        cell_value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_replies.push_back(apply_grid_item(m, r0, c0, r1, c1, v));
    endtask

    always @(posedge clk)
    begin
        cell_reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: result with no item outstanding: read_value %0d status %0b",
                         $time, read_value, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (read_value !== want.value)
                begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.value, read_value);
                    mismatch_count++;
                end
                if (status !== want.stat)
                begin
                    $display("%0t: status expected %0b actual %0b", $time, want.stat, status);
                    mismatch_count++;
                end
            end
        end
    end

    // Cover every cell first so that no later read touches unwritten data
    task automatic test_whole_grid_fill();
        send_item(MODE_FILL, '0, '0, LAST_ROW, LAST_COL, 32'sh8000_0000);
        send_item(MODE_READ, 7'd64, 7'd63, 7'd5, 7'd9, 32'sh1234_5678);
    endtask

    task automatic test_corner_cells();
        send_item(MODE_LOAD, '0, '0, LAST_ROW, LAST_COL, 32'sh7fff_ffff);
        send_item(MODE_LOAD, '0, LAST_COL, 7'd3, '0, 32'sh8000_0000);
        send_item(MODE_LOAD, LAST_ROW, '0, '0, 7'd77, -32'sd1);
        send_item(MODE_LOAD, LAST_ROW, LAST_COL, 7'd42, 7'd42, 32'sd0);
        send_item(MODE_READ, '0, '0, LAST_ROW, LAST_COL, -32'sd1);
        send_item(MODE_READ, '0, LAST_COL, '0, '0, 32'sd0);
        send_item(MODE_READ, LAST_ROW, '0, 7'd1, 7'd2, 32'sh5555_5555);
        send_item(MODE_READ, LAST_ROW, LAST_COL, LAST_ROW, LAST_COL, 32'shaaaa_aaaa);
    endtask

    task automatic test_strip_and_point_fills();
        send_item(MODE_FILL, 7'd10, 7'd20, 7'd10, 7'd20, 32'sh0bad_cafe);
        send_item(MODE_READ, 7'd10, 7'd20, '0, '0, 32'sd0);
        send_item(MODE_FILL, 7'd64, '0, 7'd64, LAST_COL, 32'sh0000_0001);
        send_item(MODE_READ, 7'd64, LAST_COL, '0, '0, 32'sd0);
        send_item(MODE_FILL, '0, LAST_COL, LAST_ROW, LAST_COL, -32'sd2);
        send_item(MODE_READ, LAST_ROW, LAST_COL, '0, '0, 32'sd0);
    endtask

    // An inverted rectangle must leave the grid untouched
    task automatic test_empty_fills();
        send_item(MODE_FILL, 7'd31, 7'd5, 7'd30, 7'd9, 32'sh1111_1111);
        send_item(MODE_READ, 7'd31, 7'd5, '0, '0, 32'sd0);
        send_item(MODE_FILL, 7'd40, LAST_COL, 7'd45, '0, 32'sh2222_2222);
        send_item(MODE_READ, 7'd40, '0, '0, '0, 32'sd0);
    endtask

    task automatic test_spare_mode();
        send_item(MODE_SPARE, LAST_ROW, LAST_COL, LAST_ROW, LAST_COL, -32'sd1);
        send_item(MODE_READ, LAST_ROW, LAST_COL, '0, '0, 32'sd0);
    endtask

    // Every 7-bit coordinate lies inside the 128 by 128 grid, so the
    // bad-coordinate status cannot arise with this configuration.
    task automatic test_random_traffic();
        int                        roll;
        int                        shape;
        int                        span;
        logic [MODE_W-1:0]         m;
        logic [COORD_W-1:0]        r0;
        logic [COORD_W-1:0]        c0;
        logic [COORD_W-1:0]        r1;
        logic [COORD_W-1:0]        c1;
        logic signed [VALUE_W-1:0] v;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(99, 0);
            r0   = COORD_W'($urandom_range(LAST_ROW, 0));
            c0   = COORD_W'($urandom_range(LAST_COL, 0));
            r1   = COORD_W'($urandom_range(LAST_ROW, 0));
            c1   = COORD_W'($urandom_range(LAST_COL, 0));
            v    = $urandom;
            if (roll < 30)
            begin
                m = MODE_LOAD;
                area_r0 = r0;
                area_c0 = c0;
                area_r1 = r0;
                area_c1 = c0;
            end
            else if (roll < 55)
            begin
                m = MODE_FILL;
                shape = $urandom_range(99, 0);
                if (shape < 2)
                begin
                    r1 = COORD_W'($urandom_range(LAST_ROW, r0));
                    c1 = COORD_W'($urandom_range(LAST_COL, c0));
                end
                else if (shape < 8)
                begin
                    r0 = COORD_W'($urandom_range(LAST_ROW, 1));
                    r1 = COORD_W'($urandom_range(r0 - 1, 0));
                end
                else if (shape < 14)
                begin
                    c0 = COORD_W'($urandom_range(LAST_COL, 1));
                    c1 = COORD_W'($urandom_range(c0 - 1, 0));
                end
                else
                begin
                    // keep most rectangles small: a fill takes time in proportion to its cells
                    span = $urandom_range(7, 0);
                    r1 = (int'(r0) + span > LAST_ROW) ? LAST_ROW : COORD_W'(int'(r0) + span);
                    span = $urandom_range(7, 0);
                    c1 = (int'(c0) + span > LAST_COL) ? LAST_COL : COORD_W'(int'(c0) + span);
                end
                if (r0 <= r1 && c0 <= c1)
                begin
                    area_r0 = r0;
                    area_c0 = c0;
                    area_r1 = r1;
                    area_c1 = c1;
                end
            end
            else if (roll < 96)
            begin
                m = MODE_READ;
                shape = $urandom_range(99, 0);
                if (shape < 45)
                begin
                    r0 = COORD_W'($urandom_range(area_r1, area_r0));
                    c0 = COORD_W'($urandom_range(area_c1, area_c0));
                end
                else if (shape < 60)
                begin
                    // probe just past the edge of the last region
                    if (area_r1 < LAST_ROW)
                        r0 = area_r1 + 1'b1;
                    else if (area_r0 > 0)
                        r0 = area_r0 - 1'b1;
                    c0 = COORD_W'($urandom_range(area_c1, area_c0));
                end
            end
            else
                m = MODE_SPARE;
            send_item(m, r0, c0, r1, c1, v);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_whole_grid_fill();
        test_corner_cells();
        test_strip_and_point_fills();
        test_empty_fills();
        test_spare_mode();
        test_random_traffic();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("** rectangle_fill_grid_store_top: PASSED **");
        else
            $display("** rectangle_fill_grid_store_top: FAILED **");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("timeout with %0d results outstanding", pending_replies.size());
        $display("** rectangle_fill_grid_store_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> rectangle_fill_grid_store_top.f
src/rfg_pkg.sv
src/rfg_ram.sv
src/rfg_walk.sv
src/rectangle_fill_grid_store_top.sv
verif/tb_rectangle_fill_grid_store_top.sv
